/* rtl/sawbc_pkg.sv */
// Package for the set-associative write-back cache.
// Holds the cache geometry, the line and set row types, the controller
// state type and the command bundle. No dependencies.
package sawbc_pkg;

  localparam int unsigned SET_COUNT  = 64;
  localparam int unsigned NUM_WAYS   = 4;
  localparam int unsigned LINE_BYTES = 4;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STAMP_W    = 32;

  // Floor of log2, so that sizes that are not powers of two use the lower power.
  function automatic int unsigned flog2(input int unsigned v);
    int unsigned n;
    int unsigned x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int unsigned OFF_W   = flog2(LINE_BYTES);
  localparam int unsigned IDX_W   = flog2(SET_COUNT);
  localparam int unsigned TAG_W   = ADDR_W - OFF_W - IDX_W;
  localparam int unsigned WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned WAYO_W  = 2;

  typedef logic [IDX_W-1:0]   set_idx_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [WAY_W-1:0]   way_idx_t;
  typedef logic [NUM_WAYS-1:0] way_mask_t;

  // One line as stored in the set memory. Valid bits live in flip-flops.
  typedef struct packed {
    tag_t               tag;
    logic [DATA_W-1:0]  word;
    logic [STAMP_W-1:0] stamp;
    logic               dirty;
  } line_t;

  typedef line_t [NUM_WAYS-1:0] set_row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the request and read its set row
    logic commit;   // resolve the lookup, update the set and post the result
  } cmd_t;

endpackage

/* rtl/set_assoc_writeback_cache_lru.sv */
// Set-associative write-back, write-allocate cache with LRU replacement.
// Top level: joins the controller and the datapath. Depends on sawbc_pkg,
// sawbc_ctrl and sawbc_dp.
//
// Usage: a request transaction (req_type_i, address_i, payload_i) is taken
// at a rising edge where start is high and busy is low. Writes store the
// word and mark the line dirty; reads return the stored word on a hit, or
// store payload_i as the clean refill and return it on a miss.
// Each request gives one result on hit_o, read_data_o, mismatch_o,
// way_used_o, evict_valid_o, write_back_o, evict_address_o and evict_data_o,
// valid for exactly one cycle while done_o is high.
// After the accepting edge the controller is in ST_LOOKUP; the edge that ends
// it writes the set and loads done_o and the result registers. busy is high
// for one cycle after acceptance, in ST_LOOKUP, so no new request is taken
// until that lookup commits: the set row is read from a single-port set memory
// in the accept cycle and written back in the lookup cycle.
// The receiver cannot stall: a result not taken in its cycle is lost.
// Reset clears all valid bits, the access counter and the controller at
// once; no clearing pass is needed, and a request may follow right away.
module set_assoc_writeback_cache_lru (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [sawbc_pkg::ADDR_W-1:0]  address_i,
  input  logic [sawbc_pkg::DATA_W-1:0]  payload_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [sawbc_pkg::DATA_W-1:0]  read_data_o,
  output logic                          mismatch_o,
  output logic [sawbc_pkg::WAYO_W-1:0]  way_used_o,
  output logic                          evict_valid_o,
  output logic                          write_back_o,
  output logic [sawbc_pkg::ADDR_W-1:0]  evict_address_o,
  output logic [sawbc_pkg::DATA_W-1:0]  evict_data_o
);

  sawbc_pkg::cmd_t cmd;

  sawbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  sawbc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_type_i),
    .address_i       (address_i),
    .payload_i       (payload_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .read_data_o     (read_data_o),
    .mismatch_o      (mismatch_o),
    .way_used_o      (way_used_o),
    .evict_valid_o   (evict_valid_o),
    .write_back_o    (write_back_o),
    .evict_address_o (evict_address_o),
    .evict_data_o    (evict_data_o)
  );

  // Every accepted transaction raises busy and then produces exactly one result.
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy ##1 done_o)
    else $error("accepted transaction did not produce a result");

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a lookup");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (evict_valid_o || write_back_o)) |-> (!hit_o && evict_valid_o))
    else $error("eviction reported on a hit or write-back without eviction");

  a_mismatch_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && mismatch_o) |-> hit_o)
    else $error("mismatch reported on a miss");

endmodule

/* rtl/sawbc_ctrl.sv */
// Controller state machine of the set-associative write-back cache.
// Depends on sawbc_pkg for the state type and the command bundle.
module sawbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output sawbc_pkg::cmd_t   cmd_o
);

  sawbc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sawbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sawbc_pkg::ST_IDLE: begin
        if (start) begin
          state_d = sawbc_pkg::ST_LOOKUP;
        end
      end
      sawbc_pkg::ST_LOOKUP: begin
        state_d = sawbc_pkg::ST_IDLE;
      end
      default: begin
        state_d = sawbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      sawbc_pkg::ST_IDLE: begin
        cmd_o.capture = start;
      end
      sawbc_pkg::ST_LOOKUP: begin
        busy         = 1'b1;
        cmd_o.commit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/sawbc_dp.sv */
// Datapath of the set-associative write-back cache: request registers, set
// memory, valid bits, access counter, hit and LRU victim logic, result registers.
// Depends on sawbc_pkg for geometry, line types and the command bundle.
module sawbc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sawbc_pkg::cmd_t               cmd_i,
  input  logic                          req_type_i,
  input  logic [sawbc_pkg::ADDR_W-1:0]  address_i,
  input  logic [sawbc_pkg::DATA_W-1:0]  payload_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [sawbc_pkg::DATA_W-1:0]  read_data_o,
  output logic                          mismatch_o,
  output logic [sawbc_pkg::WAYO_W-1:0]  way_used_o,
  output logic                          evict_valid_o,
  output logic                          write_back_o,
  output logic [sawbc_pkg::ADDR_W-1:0]  evict_address_o,
  output logic [sawbc_pkg::DATA_W-1:0]  evict_data_o
);

  localparam int unsigned SetLsb = sawbc_pkg::OFF_W;
  localparam int unsigned TagLsb = sawbc_pkg::OFF_W + sawbc_pkg::IDX_W;

  // Request registers.
  logic                         req_type_q;
  sawbc_pkg::set_idx_t          set_q;
  sawbc_pkg::tag_t              tag_q;
  logic [sawbc_pkg::DATA_W-1:0] payload_q;

  // Set memory, one row per set, and its registered read port.
  sawbc_pkg::set_row_t mem_q [sawbc_pkg::SET_COUNT];
  sawbc_pkg::set_row_t rd_row_q;
  sawbc_pkg::set_row_t wr_row;

  sawbc_pkg::way_mask_t valid_q [sawbc_pkg::SET_COUNT];
  logic [sawbc_pkg::STAMP_W-1:0] access_count_q, access_count_d;

  // Lookup results.
  sawbc_pkg::way_mask_t          set_valid;
  logic                          hit;
  sawbc_pkg::way_idx_t           sel_way;
  logic                          sel_valid;
  sawbc_pkg::line_t              sel_line;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      set_q      <= address_i[SetLsb +: sawbc_pkg::IDX_W];
      tag_q      <= address_i[TagLsb +: sawbc_pkg::TAG_W];
      payload_q  <= payload_i;
      rd_row_q   <= mem_q[address_i[SetLsb +: sawbc_pkg::IDX_W]];
    end
    if (cmd_i.commit) begin
      mem_q[set_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sawbc_pkg::SET_COUNT; s++) begin
        valid_q[s] <= '0;
      end
      access_count_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q[set_q][sel_way] <= 1'b1;
      access_count_q          <= access_count_d;
    end
  end

  assign access_count_d = access_count_q + 1'b1;
  assign set_valid      = valid_q[set_q];

  // Hit search takes the lowest matching way. On a miss the victim is the way
  // with the smallest stamp, lowest way on ties; a line never filled has stamp zero.
  always_comb begin
    logic [sawbc_pkg::STAMP_W-1:0] best_stamp;
    logic [sawbc_pkg::STAMP_W-1:0] cur_stamp;
    sawbc_pkg::way_idx_t           hit_way;
    sawbc_pkg::way_idx_t           lru_way;
    hit        = 1'b0;
    hit_way    = '0;
    for (int w = sawbc_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (set_valid[w] && (rd_row_q[w].tag == tag_q)) begin
        hit     = 1'b1;
        hit_way = sawbc_pkg::WAY_W'(w);
      end
    end
    lru_way    = '0;
    best_stamp = set_valid[0] ? rd_row_q[0].stamp : '0;
    for (int w = 1; w < sawbc_pkg::NUM_WAYS; w++) begin
      cur_stamp = set_valid[w] ? rd_row_q[w].stamp : '0;
      if (cur_stamp < best_stamp) begin
        best_stamp = cur_stamp;
        lru_way    = sawbc_pkg::WAY_W'(w);
      end
    end
    sel_way   = hit ? hit_way : lru_way;
    sel_valid = set_valid[sel_way];
    sel_line  = rd_row_q[sel_way];
  end

  always_comb begin
    wr_row = rd_row_q;
    wr_row[sel_way].stamp = access_count_d;
    if (hit) begin
      if (req_type_q == sawbc_pkg::REQ_WRITE) begin
        wr_row[sel_way].word  = payload_q;
        wr_row[sel_way].dirty = 1'b1;
      end
    end else begin
      wr_row[sel_way].tag   = tag_q;
      wr_row[sel_way].word  = payload_q;
      wr_row[sel_way].dirty = (req_type_q == sawbc_pkg::REQ_WRITE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= hit;
      way_used_o    <= sawbc_pkg::WAYO_W'(sel_way);
      evict_valid_o <= !hit && sel_valid;
      write_back_o  <= !hit && sel_valid && sel_line.dirty;
      if (req_type_q == sawbc_pkg::REQ_READ) begin
        read_data_o <= hit ? sel_line.word : payload_q;
        mismatch_o  <= hit && (sel_line.word != payload_q);
      end else begin
        read_data_o <= '0;
        mismatch_o  <= 1'b0;
      end
      if (!hit && sel_valid) begin
        evict_address_o <= {sel_line.tag, set_q, {sawbc_pkg::OFF_W{1'b0}}};
        evict_data_o    <= sel_line.word;
      end else begin
        evict_address_o <= '0;
        evict_data_o    <= '0;
      end
    end
  end

endmodule

/* bench/tb_set_assoc_writeback_cache_lru.sv */
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_writeback_cache_lru. It predicts every result
// of the cache and checks it. Depends on sawbc_pkg and the cache RTL only.
module tb_set_assoc_writeback_cache_lru;

  localparam int unsigned NUM_LINES   = sawbc_pkg::SET_COUNT * sawbc_pkg::NUM_WAYS;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    logic                         hit;
    logic [sawbc_pkg::DATA_W-1:0] read_data;
    logic                         mismatch;
    logic [sawbc_pkg::WAYO_W-1:0] way_used;
    logic                         evict_valid;
    logic                         write_back;
    logic [sawbc_pkg::ADDR_W-1:0] evict_address;
    logic [sawbc_pkg::DATA_W-1:0] evict_data;
  } cache_resp_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic                         req_type_i;
  logic [sawbc_pkg::ADDR_W-1:0] address_i;
  logic [sawbc_pkg::DATA_W-1:0] payload_i;
  logic                         done_o;
  logic                         hit_o;
  logic [sawbc_pkg::DATA_W-1:0] read_data_o;
  logic                         mismatch_o;
  logic [sawbc_pkg::WAYO_W-1:0] way_used_o;
  logic                         evict_valid_o;
  logic                         write_back_o;
  logic [sawbc_pkg::ADDR_W-1:0] evict_address_o;
  logic [sawbc_pkg::DATA_W-1:0] evict_data_o;

  set_assoc_writeback_cache_lru u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .address_i       (address_i),
    .payload_i       (payload_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .read_data_o     (read_data_o),
    .mismatch_o      (mismatch_o),
    .way_used_o      (way_used_o),
    .evict_valid_o   (evict_valid_o),
    .write_back_o    (write_back_o),
    .evict_address_o (evict_address_o),
    .evict_data_o    (evict_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the cache contents.
  sawbc_pkg::tag_t               line_tag   [NUM_LINES];
  logic [sawbc_pkg::DATA_W-1:0]  line_word  [NUM_LINES];
  bit                            line_valid [NUM_LINES];
  bit                            line_dirty [NUM_LINES];
  logic [sawbc_pkg::STAMP_W-1:0] line_stamp [NUM_LINES];
  logic [sawbc_pkg::STAMP_W-1:0] access_count;

  cache_resp_t pending_resp_q[$];
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  // Applies one request to the shadow cache and returns the result it must produce.
  function automatic cache_resp_t lru_cache_access(sawbc_pkg::req_e kind,
                                                   logic [sawbc_pkg::ADDR_W-1:0] addr,
                                                   logic [sawbc_pkg::DATA_W-1:0] data);
    cache_resp_t         resp;
    sawbc_pkg::set_idx_t set;
    sawbc_pkg::tag_t     tag;
    int unsigned         base;
    int unsigned         way;
    int unsigned         li;
    bit                  found;
    resp  = '0;
    set   = addr[sawbc_pkg::OFF_W +: sawbc_pkg::IDX_W];
    tag   = addr[sawbc_pkg::ADDR_W-1 -: sawbc_pkg::TAG_W];
    base  = set * sawbc_pkg::NUM_WAYS;
    way   = 0;
    found = 1'b0;
    access_count = access_count + 1;
    for (int unsigned w = 0; w < sawbc_pkg::NUM_WAYS; w++) begin
      if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    // Oldest stamp loses; the strict compare keeps ties on the lowest way.
    if (!found) begin
      for (int unsigned w = 1; w < sawbc_pkg::NUM_WAYS; w++) begin
        if (line_stamp[base + w] < line_stamp[base + way]) way = w;
      end
    end
    li = base + way;
    if (found) begin
      if (kind == sawbc_pkg::REQ_WRITE) begin
        line_word[li]  = data;
        line_dirty[li] = 1'b1;
      end else begin
        resp.read_data = line_word[li];
        resp.mismatch  = line_word[li] != data;
      end
    end else begin
      if (line_valid[li]) begin
        resp.evict_valid   = 1'b1;
        resp.write_back    = line_dirty[li];
        resp.evict_address = {line_tag[li], set, {sawbc_pkg::OFF_W{1'b0}}};
        resp.evict_data    = line_word[li];
      end
      line_tag[li]   = tag;
      line_word[li]  = data;
      line_valid[li] = 1'b1;
      line_dirty[li] = kind == sawbc_pkg::REQ_WRITE;
      if (kind == sawbc_pkg::REQ_READ) resp.read_data = data;
    end
    line_stamp[li] = access_count;
    resp.hit       = found;
    resp.way_used  = way[sawbc_pkg::WAYO_W-1:0];
    return resp;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  // Start is left high so that a following request can go back to back.
  task automatic send_request(sawbc_pkg::req_e kind, logic [sawbc_pkg::ADDR_W-1:0] addr,
                              logic [sawbc_pkg::DATA_W-1:0] data, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= kind;
    address_i  <= addr;
    payload_i  <= data;
    do @(posedge clk_i); while (busy);
    pending_resp_q.push_back(lru_cache_access(kind, addr, data));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_resp_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [sawbc_pkg::ADDR_W-1:0] make_addr(
      sawbc_pkg::tag_t tag, sawbc_pkg::set_idx_t set, logic [sawbc_pkg::OFF_W-1:0] off);
    return {tag, set, off};
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cache_resp_t exp_resp;
    if (rst_ni && done_o) begin
      if (pending_resp_q.size() == 0) begin
        $error("result transaction with no request outstanding");
        fail_count++;
      end else begin
        exp_resp = pending_resp_q.pop_front();
        check_field("hit", 32'(exp_resp.hit), 32'(hit_o));
        check_field("read_data", exp_resp.read_data, read_data_o);
        check_field("mismatch", 32'(exp_resp.mismatch), 32'(mismatch_o));
        check_field("way_used", 32'(exp_resp.way_used), 32'(way_used_o));
        check_field("evict_valid", 32'(exp_resp.evict_valid), 32'(evict_valid_o));
        check_field("write_back", 32'(exp_resp.write_back), 32'(write_back_o));
        check_field("evict_address", exp_resp.evict_address, evict_address_o);
        check_field("evict_data", exp_resp.evict_data, evict_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("set_assoc_writeback_cache_lru test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Fills one set from empty, then forces dirty and clean evictions.
  task automatic test_way_fill_and_eviction();
    sawbc_pkg::set_idx_t set;
    set = 6'd5;
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h1, set, 2'd0), 32'hA5A5_0001,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_WRITE, make_addr(24'h2, set, 2'd1), 32'h0000_0002,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_WRITE, make_addr(24'h3, set, 2'd2), 32'h0000_0003,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_WRITE, make_addr(24'h4, set, 2'd3), 32'h0000_0004,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_WRITE, make_addr(24'h5, set, 2'd0), 32'h0000_0005,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h6, set, 2'd0), 32'h0000_0006,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_WRITE, make_addr(24'h1, set, 2'd0), 32'h1111_1111, 0);
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h3, set, 2'd0), 32'h0000_0033, 0);
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h7, set, 2'd0), 32'h0000_0077, 0);
  endtask

  task automatic test_read_hit_compare();
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h1, 6'd5, 2'd2), 32'h1111_1111,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h1, 6'd5, 2'd1), 32'h1111_1110,
                 $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_READ, make_addr(24'h7, 6'd5, 2'd3), 32'hFFFF_FFFF, 0);
  endtask

  task automatic test_address_extremes();
    send_request(sawbc_pkg::REQ_READ, 32'h0000_0000, 32'h0000_0000, $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_request(sawbc_pkg::REQ_READ, 32'h0000_0003, 32'h0000_0000, 0);
    send_request(sawbc_pkg::REQ_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_READ, 32'hFFFF_FFFC, 32'h0000_0000, 0);
    send_request(sawbc_pkg::REQ_READ, 32'hFFFF_FFFF, 32'h8000_0001, 0);
    send_request(sawbc_pkg::REQ_WRITE, 32'hFFFF_FFF0, 32'h5555_AAAA, $urandom_range(0, 5));
    send_request(sawbc_pkg::REQ_READ, 32'h0000_00FC, 32'hAAAA_5555, 0);
  endtask

  // Mostly a few hot sets and tags, so that hits and evictions are frequent.
  task automatic test_random_traffic(int unsigned count);
    sawbc_pkg::set_idx_t          hot_set [4];
    sawbc_pkg::tag_t              hot_tag [6];
    sawbc_pkg::set_idx_t          set;
    sawbc_pkg::tag_t              tag;
    sawbc_pkg::req_e              kind;
    logic [sawbc_pkg::ADDR_W-1:0] addr;
    logic [sawbc_pkg::DATA_W-1:0] data;
    int unsigned                  base;
    bit                           no_gaps;
    foreach (hot_set[i]) hot_set[i] = sawbc_pkg::IDX_W'($urandom());
    foreach (hot_tag[i]) hot_tag[i] = sawbc_pkg::TAG_W'($urandom());
    no_gaps = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = $urandom_range(0, 2) == 0;
      if (n % 120 == 119) drain_results();
      kind = $urandom_range(0, 1) ? sawbc_pkg::REQ_WRITE : sawbc_pkg::REQ_READ;
      data = $urandom();
      if ($urandom_range(0, 99) < 15) begin
        addr = $urandom();
      end else begin
        set  = hot_set[$urandom_range(0, 3)];
        tag  = hot_tag[$urandom_range(0, 5)];
        addr = make_addr(tag, set, sawbc_pkg::OFF_W'($urandom_range(0, 3)));
        // Half the read hits carry the stored word, so both compare outcomes occur.
        base = set * sawbc_pkg::NUM_WAYS;
        for (int unsigned w = 0; w < sawbc_pkg::NUM_WAYS; w++) begin
          if (kind == sawbc_pkg::REQ_READ && line_valid[base + w] &&
              line_tag[base + w] == tag && $urandom_range(0, 1) == 1) begin
            data = line_word[base + w];
          end
        end
      end
      send_request(kind, addr, data, no_gaps ? 0 : $urandom_range(0, 5));
    end
  endtask

  initial begin
    access_count = '0;
    foreach (line_tag[i]) begin
      line_tag[i]   = '0;
      line_word[i]  = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_stamp[i] = '0;
    end
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_type_i <= sawbc_pkg::REQ_READ;
    address_i  <= '0;
    payload_i  <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_way_fill_and_eviction();
    test_read_hit_compare();
    test_address_extremes();
    drain_results();
    test_random_traffic(400);
    drain_results();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("set_assoc_writeback_cache_lru test passed");
    end else begin
      $display("set_assoc_writeback_cache_lru test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sawbc_pkg.sv
rtl/sawbc_ctrl.sv
rtl/sawbc_dp.sv
rtl/set_assoc_writeback_cache_lru.sv
bench/tb_set_assoc_writeback_cache_lru.sv
